// ===== sv/bkst_pkg.sv =====
`default_nettype none

package bkst_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_BITS = 16;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CFG_W = 8;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(100);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_TOGGLE = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_PRESENT  = 3'd5,
		ST_ABSENT   = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE  = 4'b0001,
		FSM_SCAN  = 4'b0010,
		FSM_SHIFT = 4'b0100,
		FSM_DONE  = 4'b1000
	} fsm_t;

endpackage

`default_nettype wire

// ===== sv/bkst_ram.sv =====
`default_nettype none

module bkst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bounded_key_set_table_core.sv =====
`default_nettype none

// bounded key set table: holds a packed list of up to CAPACITY distinct keys in a single-port-read
// RAM and serves one request transaction at a time (add, remove, toggle, query), answering each
// with one result transaction carrying a status code and the entry count after the request.
// adds are refused with "full" once the count reaches min(max_entries, CAPACITY); the limit is
// checked before the duplicate search. an add to a full table goes straight to the done state
// without a scan; any other request scans the list one entry per cycle through the RAM read
// port, and a removal then moves the later entries down one per cycle. the RAM read port is the
// shared unit that paces both passes. s_tready is high only while the sequencer is idle; a
// finished result waits in the output register, and the next request is taken as soon as that
// result has been handed over or is held there. no clearing pass is needed after reset: only
// entries below the count are ever read.

module bounded_key_set_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: max_entries
	input  wire logic        cfg_wen,
	input  wire logic [7:0]  cfg_wdata,
	// request stream, tdata: mode[1:0], key[17:2], zero[23:18]
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,
	// result stream, tdata: status[2:0], entry_count[10:3], zero[15:11]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata
);

	import bkst_pkg::*;

	// sequencer and request registers
	fsm_t                state_q;
	mode_t               mode_q;
	logic [KEY_BITS-1:0] key_q;
	status_t             res_q;

	// table state
	logic [CNT_W-1:0]    count_q;
	logic [CFG_W-1:0]    max_entries_q;

	// read pointer and the read in flight from the registered RAM read port
	logic [CNT_W-1:0]    idx_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;

	// output register
	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;

	// RAM ports
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [KEY_BITS-1:0] ram_rdata;

	// derived control
	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    limit;
	logic                full;
	logic                more;
	logic                hit;
	logic                walk_end;
	logic                append;
	logic                out_free;

	assign cnt_ext  = CMP_W'(count_q);
	assign limit    = (CMP_W'(max_entries_q) > CMP_W'(CAPACITY))
		? CMP_W'(CAPACITY) : CMP_W'(max_entries_q);
	assign full     = (cnt_ext >= limit);
	assign more     = (idx_q < count_q);
	assign hit      = vld_s1 && (ram_rdata == key_q);
	// nothing left to issue and nothing in flight
	assign walk_end = !vld_s1 && !more;
	// append on a miss: add (limit already checked at accept) or toggle with room
	assign append   = (mode_q == MODE_ADD) || ((mode_q == MODE_TOGGLE) && !full);
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == FSM_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one read per cycle while scanning or shifting, as long as entries below the count remain
	assign ram_re = ((state_q == FSM_SCAN) || (state_q == FSM_SHIFT)) && more;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = key_q;
		if (state_q == FSM_SHIFT) begin
			// entry just read moves down one place
			ram_we    = vld_s1;
			ram_waddr = idx_s1 - IDX_W'(1);
			ram_wdata = ram_rdata;
		end else if (state_q == FSM_SCAN) begin
			// miss: new key goes to the end of the list
			ram_we    = !hit && walk_end && append;
		end
	end

	bkst_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			mode_q        <= MODE_ADD;
			key_q         <= '0;
			res_q         <= ST_ADDED;
			count_q       <= '0;
			max_entries_q <= MAX_ENTRIES_RST;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (cfg_wen) begin
				max_entries_q <= cfg_wdata;
			end

			// result taken downstream; the done state reloads it itself
			if (m_tvalid_q && m_tready && (state_q != FSM_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				FSM_IDLE: begin
					if (s_tvalid) begin
						mode_q <= mode_t'(s_tdata[1:0]);
						key_q  <= s_tdata[2 +: KEY_BITS];
						idx_q  <= '0;
						vld_s1 <= 1'b0;
						// full is answered before any duplicate search
						if ((mode_t'(s_tdata[1:0]) == MODE_ADD) && full) begin
							res_q   <= ST_FULL;
							state_q <= FSM_DONE;
						end else begin
							state_q <= FSM_SCAN;
						end
					end
				end

				FSM_SCAN: begin
					if (hit) begin
						unique case (mode_q)
							MODE_ADD: begin
								res_q   <= ST_DUP;
								state_q <= FSM_DONE;
							end
							MODE_REMOVE, MODE_TOGGLE: begin
								// close the gap, starting with the entry after the match
								idx_q   <= CNT_W'(idx_s1) + CNT_W'(1);
								vld_s1  <= 1'b0;
								state_q <= FSM_SHIFT;
							end
							MODE_QUERY: begin
								res_q   <= ST_PRESENT;
								state_q <= FSM_DONE;
							end
							default: begin
								state_q <= FSM_DONE;
							end
						endcase
					end else if (walk_end) begin
						unique case (mode_q)
							MODE_ADD: begin
								count_q <= count_q + CNT_W'(1);
								res_q   <= ST_ADDED;
							end
							MODE_REMOVE: begin
								res_q <= ST_NOTFOUND;
							end
							MODE_TOGGLE: begin
								if (full) begin
									res_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									res_q   <= ST_ADDED;
								end
							end
							MODE_QUERY: begin
								res_q <= ST_ABSENT;
							end
							default: begin
								res_q <= ST_ABSENT;
							end
						endcase
						state_q <= FSM_DONE;
					end else begin
						vld_s1 <= ram_re;
						idx_s1 <= idx_q[IDX_W-1:0];
						if (ram_re) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end

				FSM_SHIFT: begin
					if (walk_end) begin
						count_q <= count_q - CNT_W'(1);
						res_q   <= ST_REMOVED;
						state_q <= FSM_DONE;
					end else begin
						vld_s1 <= ram_re;
						idx_s1 <= idx_q[IDX_W-1:0];
						if (ram_re) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end

				FSM_DONE: begin
					// hand the result to the output register once it is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'd0, cnt_ext[7:0], res_q};
						state_q    <= FSM_IDLE;
					end
				end

				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("entry count above capacity");

	// the store is written only while scanning or shifting
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == FSM_SCAN) || (state_q == FSM_SHIFT)))
		else $error("store written outside scan or shift");

	// an accepted request leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != FSM_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// during a shift the count only changes on the way out, by one
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SHIFT) |=> ((count_q == $past(count_q))
			|| ((state_q == FSM_DONE) && (count_q == $past(count_q) - CNT_W'(1)))))
		else $error("count changed unexpectedly during shift");

	// a new result is loaded only when the output register was free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == FSM_DONE) && !out_free) |=> (state_q == FSM_DONE))
		else $error("result left done state while output was held");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_bounded_key_set_table_core.sv =====
`default_nettype none

module tb_bounded_key_set_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bkst_pkg::*;

	// one expected result transaction: status and entry count after the request
	typedef struct packed {
		status_t    status;
		logic [7:0] count;
	} table_reply_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = 24'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;

	// shadow copy of the table, kept in acceptance order
	logic [15:0]  shadow_keys [CAPACITY];
	int           shadow_count = 0;
	logic [7:0]   shadow_limit = MAX_ENTRIES_RST;
	table_reply_t replies_due [$];

	// idle control: when set, that side never inserts gaps
	bit sender_quiet = 1'b0;
	bit sink_quiet   = 1'b0;

	int mismatch_count = 0;
	int requests_sent  = 0;
	int results_seen   = 0;
	int status_seen [7];

	bounded_key_set_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// applies one request to the shadow table and returns the status it must answer
	function automatic status_t predict_reply(input mode_t op, input logic [15:0] k);
		int slot;
		int cap_now;
		int i;
		slot = -1;
		for (i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == k) begin
				slot = i;
				break;
			end
		end
		// limit in force is clamped to the table size
		cap_now = (shadow_limit < CAPACITY) ? shadow_limit : CAPACITY;
		if (op == MODE_QUERY)
			return (slot >= 0) ? ST_PRESENT : ST_ABSENT;
		// plain remove, or toggle of a stored key
		if (op == MODE_REMOVE || (op == MODE_TOGGLE && slot >= 0)) begin
			if (slot < 0)
				return ST_NOTFOUND;
			for (i = slot; i + 1 < shadow_count; i++)
				shadow_keys[i] = shadow_keys[i + 1];
			shadow_count--;
			return ST_REMOVED;
		end
		// add, or toggle of an absent key: the limit is checked before the duplicate test
		if (shadow_count >= cap_now)
			return ST_FULL;
		if (slot >= 0)
			return ST_DUP;
		shadow_keys[shadow_count] = k;
		shadow_count++;
		return ST_ADDED;
	endfunction

	// drives one request transaction and records its expected result on acceptance
	task automatic send_request(input mode_t op, input logic [15:0] k);
		int gap;
		table_reply_t due;
		gap = sender_quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, k, op};
		do @(posedge clk); while (!s_tready);
		due.status = predict_reply(op, k);
		due.count  = 8'(shadow_count);
		replies_due.push_back(due);
		requests_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_table_idle();
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_entries(input logic [7:0] value);
		wait_table_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		shadow_limit = value;
	endtask

	// every mode on an empty and a small table, keys at both extremes
	task automatic test_basic_ops();
		send_request(MODE_QUERY, 16'h0000);
		send_request(MODE_REMOVE, 16'h0000);
		send_request(MODE_ADD, 16'h0000);
		send_request(MODE_ADD, 16'hFFFF);
		send_request(MODE_ADD, 16'h0000);
		send_request(MODE_QUERY, 16'hFFFF);
		send_request(MODE_TOGGLE, 16'h5555);
		send_request(MODE_TOGGLE, 16'h0000);
		send_request(MODE_REMOVE, 16'hFFFF);
		send_request(MODE_TOGGLE, 16'h5555);
	endtask

	// a zero limit refuses every add and every toggle of an absent key
	task automatic test_zero_limit();
		write_max_entries(8'd0);
		send_request(MODE_ADD, 16'hAAAA);
		send_request(MODE_TOGGLE, 16'hAAAA);
		send_request(MODE_REMOVE, 16'hAAAA);
	endtask

	// full wins over duplicate, and lowering the limit under the count drops nothing
	task automatic test_limit_below_count();
		sender_quiet = 1'b1;
		sink_quiet   = 1'b1;
		write_max_entries(8'd2);
		send_request(MODE_ADD, 16'h0001);
		send_request(MODE_ADD, 16'h0002);
		send_request(MODE_ADD, 16'h0001);
		send_request(MODE_TOGGLE, 16'h0002);
		send_request(MODE_ADD, 16'h0001);
		send_request(MODE_ADD, 16'h0003);
		write_max_entries(8'd1);
		send_request(MODE_ADD, 16'h0009);
		send_request(MODE_REMOVE, 16'h0001);
		send_request(MODE_ADD, 16'h0009);
		send_request(MODE_REMOVE, 16'h0003);
		send_request(MODE_ADD, 16'h0009);
		send_request(MODE_REMOVE, 16'h0009);
		sender_quiet = 1'b0;
		sink_quiet   = 1'b0;
	endtask

	// fill all 128 slots under a limit above capacity, then empty in random order
	task automatic test_capacity_clamp();
		logic [15:0] fill_keys [CAPACITY];
		logic [15:0] swap_key;
		int i;
		int j;
		write_max_entries(8'd255);
		sender_quiet = 1'b1;
		// the low 7 bits make every fill key distinct
		for (i = 0; i < CAPACITY; i++) begin
			fill_keys[i] = {9'($urandom_range(0, 511)), 7'(i)};
			send_request(MODE_ADD, fill_keys[i]);
		end
		send_request(MODE_ADD, fill_keys[0] ^ 16'h0080);
		send_request(MODE_ADD, fill_keys[5]);
		send_request(MODE_TOGGLE, fill_keys[9] ^ 16'h8000);
		send_request(MODE_QUERY, fill_keys[CAPACITY - 1]);
		write_max_entries(8'd128);
		send_request(MODE_ADD, fill_keys[3] ^ 16'h0100);
		for (i = CAPACITY - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap_key     = fill_keys[i];
			fill_keys[i] = fill_keys[j];
			fill_keys[j] = swap_key;
		end
		sender_quiet = 1'b0;
		for (i = 0; i < CAPACITY; i++)
			send_request(MODE_TOGGLE, fill_keys[i]);
	endtask

	// mixed traffic on a small key pool so hits, misses and full answers all occur
	task automatic test_random_traffic(input int n_items, input int pool_n,
		input logic [7:0] limit_val);
		logic [15:0] key_pool [$];
		logic [15:0] k;
		mode_t op;
		int i;
		int pick;
		write_max_entries(limit_val);
		for (i = 0; i < pool_n; i++)
			key_pool.push_back(16'($urandom));
		for (i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				sender_quiet = ($urandom_range(0, 3) == 0);
				sink_quiet   = ($urandom_range(0, 3) == 0);
			end
			// mid-phase hold-off until the table has answered everything
			if (i == n_items / 2)
				wait_table_idle();
			pick = $urandom_range(0, 99);
			if (pick < 35)
				op = MODE_ADD;
			else if (pick < 55)
				op = MODE_REMOVE;
			else if (pick < 80)
				op = MODE_TOGGLE;
			else
				op = MODE_QUERY;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, pool_n - 1)];
			else
				k = 16'($urandom);
			send_request(op, k);
		end
		sender_quiet = 1'b0;
		sink_quiet   = 1'b0;
	endtask

	// result side: random stall before each result transaction
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		table_reply_t due;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", m_tdata));
			end else begin
				due = replies_due.pop_front();
				if (m_tdata[2:0] !== due.status)
					report_mismatch($sformatf("status %0d, expected %s",
						m_tdata[2:0], due.status.name()));
				if (m_tdata[10:3] !== due.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						m_tdata[10:3], due.count));
				status_seen[due.status]++;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_zero_limit();
		test_limit_below_count();
		test_capacity_clamp();
		test_random_traffic(44, 12, 8'd8);
		test_random_traffic(44, 8, 8'd0);
		test_random_traffic(44, 200, 8'd255);
		test_random_traffic(44, 40, 8'd128);
		test_random_traffic(44, 30, 8'($urandom_range(1, 255)));
		test_random_traffic(44, 6, 8'd3);
		wait_table_idle();
		// a late or spurious result would still show up here
		repeat (150) @(posedge clk);
		$display("covered %0d requests and %0d results, limits 0 to 255 and a full table of %0d",
			requests_sent, results_seen, CAPACITY);
		$display("answers: added %0d removed %0d dup %0d full %0d missing %0d present %0d absent %0d",
			status_seen[ST_ADDED], status_seen[ST_REMOVED], status_seen[ST_DUP],
			status_seen[ST_FULL], status_seen[ST_NOTFOUND], status_seen[ST_PRESENT],
			status_seen[ST_ABSENT]);
		if (mismatch_count == 0) begin
			$display("[bounded_key_set_table_core] OK");
		end else begin
			$display("[bounded_key_set_table_core] ERROR");
		end
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#8_000_000;
		$display("timeout with %0d results pending", replies_due.size());
		$display("[bounded_key_set_table_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
